// ===== hw/rtl/i2cra_pkg.sv =====
// Shared types and constants of the I2C register access master.
package i2cra_pkg;

  localparam logic [15:0] PHASE_TICKS_RESET = 16'd250;
  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd5000;

  // Configuration register indexes
  localparam logic [7:0] CFG_PHASE_TICKS = 8'd0;
  localparam logic [7:0] CFG_ACK_TIMEOUT = 8'd1;

  // Command codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] ADDR_WRITE_MASK = 8'hfe;
  localparam logic [7:0] ADDR_READ_BIT   = 8'h01;

  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_S_HI     = 16'h0002,
    ST_S_FALL   = 16'h0004,
    ST_S_LOW    = 16'h0008,
    ST_R_REL    = 16'h0010,
    ST_R_HI     = 16'h0020,
    ST_R_FALL   = 16'h0040,
    ST_R_LOW    = 16'h0080,
    ST_TX       = 16'h0100,
    ST_RX_LOW   = 16'h0200,
    ST_RX_HI    = 16'h0400,
    ST_MACK_LOW = 16'h0800,
    ST_MACK_HI  = 16'h1000,
    ST_STOP_LOW = 16'h2000,
    ST_STOP_HI  = 16'h4000,
    ST_STOP_REL = 16'h8000
  } step_t;

  // Which byte is being shifted out
  typedef enum logic [1:0] {
    ROLE_ADDR_W = 2'd0,
    ROLE_REG    = 2'd1,
    ROLE_DATA   = 2'd2,
    ROLE_ADDR_R = 2'd3
  } role_t;

  // Sub-phase of a transmitted byte
  typedef enum logic [1:0] {
    SUB_BIT_LOW  = 2'd0,
    SUB_BIT_HIGH = 2'd1,
    SUB_ACK_WAIT = 2'd2,
    SUB_ACK_HIGH = 2'd3
  } sub_t;

  typedef struct packed {
    logic       scl;
    logic       sda_release;
    logic       busy_res;
    logic [7:0] read_data;
    logic       read_valid;
    logic       last_byte;
    logic       ack_missing;
    logic       done_res;
    logic       rejected;
  } result_t;

endpackage

// ===== hw/rtl/i2c_register_access_master.sv =====
// Top level of the I2C register access master: handshakes, settings and result word.
//
// I2C master for single-register writes and multi-byte register reads. Each input
// word is one bus tick: it carries the sampled SDA level and, optionally, a command
// (op 1 write one register, op 2 read read_count registers; op 0 or 3 is a plain tick).
// A command taken while idle runs START, address+W, register byte, then either data
// byte and STOP, or repeated START, address+R, the requested bytes (ACK on each,
// NACK on the last) and STOP. Every SCL/SDA phase lasts phase_ticks ticks; an ACK
// wait that sees no low SDA for ack_timeout ticks pulses ack_missing and carries on
// without a clock pulse. A command arriving while busy is dropped and flagged with
// rejected. Every input word yields exactly one result word with the line levels
// after that tick. Throughput is one word per clock: the sequencer step logic sits
// between the state registers and the result register, and a new word is taken
// whenever the result register is empty or being drained in the same cycle. Result
// valid rises in the cycle after acceptance. The user writes settings via the config
// channel while no transaction runs, unenforced by the block. cfg_ready is always high.
module i2c_register_access_master
  import i2cra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  device_id,
  input  logic [7:0]  register_address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  read_count,
  input  logic        sda_in,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl,
  output logic        sda_release,
  output logic        busy_res,
  output logic [7:0]  read_data,
  output logic        read_valid,
  output logic        last_byte,
  output logic        ack_missing,
  output logic        done_res,
  output logic        rejected
);

  logic [15:0] phase_ticks;
  logic [15:0] ack_timeout;
  logic        accept;
  result_t     res;
  result_t     res_q;

  // Config writes are always taken; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
      ack_timeout <= ACK_TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PHASE_TICKS: phase_ticks <= cfg_data;
        CFG_ACK_TIMEOUT: ack_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // Take a new word whenever the result register frees up this cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  i2cra_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .advance          (accept),
    .phase_ticks      (phase_ticks),
    .ack_timeout      (ack_timeout),
    .op               (op),
    .device_id        (device_id),
    .register_address (register_address),
    .write_data       (write_data),
    .read_count       (read_count),
    .sda_in           (sda_in),
    .res              (res)
  );

  // Result register: load on accept, drop valid once the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign scl         = res_q.scl;
  assign sda_release = res_q.sda_release;
  assign busy_res    = res_q.busy_res;
  assign read_data   = res_q.read_data;
  assign read_valid  = res_q.read_valid;
  assign last_byte   = res_q.last_byte;
  assign ack_missing = res_q.ack_missing;
  assign done_res    = res_q.done_res;
  assign rejected    = res_q.rejected;

endmodule

// ===== hw/rtl/i2cra_seq.sv =====
// Bus sequencer: step state, next-step logic and line levels for one tick.
module i2cra_seq
  import i2cra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [15:0] phase_ticks,
  input  logic [15:0] ack_timeout,
  input  logic [1:0]  op,
  input  logic [7:0]  device_id,
  input  logic [7:0]  register_address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  read_count,
  input  logic        sda_in,
  output result_t     res
);

  step_t       step, step_next;
  role_t       role, role_next;
  sub_t        sub, sub_next;
  logic [15:0] phase_count, phase_count_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] ack_wait_count, ack_wait_count_next;
  logic [7:0]  latched_device, latched_device_next;
  logic [7:0]  latched_register, latched_register_next;
  logic [7:0]  latched_data, latched_data_next;
  logic        is_read, is_read_next;

  logic [15:0] phase_lim, ack_lim;
  logic [16:0] phase_inc, ack_inc;
  logic        phase_over, ack_over, cmd, ack_done;
  logic [7:0]  rx_byte;

  always_comb begin
    phase_lim  = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    ack_lim    = (ack_timeout == 16'd0) ? 16'd1 : ack_timeout;
    phase_inc  = {1'b0, phase_count} + 17'd1;
    ack_inc    = {1'b0, ack_wait_count} + 17'd1;
    phase_over = phase_inc >= {1'b0, phase_lim};
    ack_over   = ack_inc >= {1'b0, ack_lim};
    cmd        = (op == OP_WRITE) || (op == OP_READ);
    rx_byte    = shift_byte | (8'(sda_in) << bit_index);
  end

  always_comb begin
    step_next             = step;
    role_next             = role;
    sub_next              = sub;
    phase_count_next      = phase_count;
    bit_index_next        = bit_index;
    shift_byte_next       = shift_byte;
    bytes_left_next       = bytes_left;
    ack_wait_count_next   = ack_wait_count;
    latched_device_next   = latched_device;
    latched_register_next = latched_register;
    latched_data_next     = latched_data;
    is_read_next          = is_read;
    ack_done              = 1'b0;
    res                   = '0;

    if (step != ST_IDLE) begin
      res.rejected = cmd;
    end

    unique case (step)
      ST_IDLE: begin
        if (cmd) begin
          latched_device_next   = device_id;
          latched_register_next = register_address;
          latched_data_next     = write_data;
          bytes_left_next       = (read_count == 8'd0) ? 8'd1 : read_count;
          is_read_next          = (op == OP_READ);
          step_next             = ST_S_HI;
          phase_count_next      = '0;
        end
      end
      ST_TX: begin
        if (sub == SUB_ACK_WAIT) begin
          if (!sda_in) begin
            sub_next         = SUB_ACK_HIGH;
            phase_count_next = '0;
          end else if (ack_over) begin
            ack_wait_count_next = '0;
            res.ack_missing     = 1'b1;
            ack_done            = 1'b1;
          end else begin
            ack_wait_count_next = ack_inc[15:0];
          end
        end else if (phase_over) begin
          phase_count_next = '0;
          case (sub)
            SUB_BIT_LOW: sub_next = SUB_BIT_HIGH;
            SUB_BIT_HIGH: begin
              if (bit_index == 3'd0) begin
                ack_wait_count_next = '0;
                sub_next            = SUB_ACK_WAIT;
              end else begin
                bit_index_next = bit_index - 3'd1;
                sub_next       = SUB_BIT_LOW;
              end
            end
            default: ack_done = 1'b1;
          endcase
        end else begin
          phase_count_next = phase_inc[15:0];
        end
      end
      default: begin
        if (phase_over) begin
          phase_count_next = '0;
          unique case (step)
            ST_S_HI:   step_next = ST_S_FALL;
            ST_S_FALL: step_next = ST_S_LOW;
            ST_S_LOW: begin
              shift_byte_next = latched_device & ADDR_WRITE_MASK;
              bit_index_next  = 3'd7;
              role_next       = ROLE_ADDR_W;
              sub_next        = SUB_BIT_LOW;
              step_next       = ST_TX;
            end
            ST_R_REL:  step_next = ST_R_HI;
            ST_R_HI:   step_next = ST_R_FALL;
            ST_R_FALL: step_next = ST_R_LOW;
            ST_R_LOW: begin
              shift_byte_next = latched_device | ADDR_READ_BIT;
              bit_index_next  = 3'd7;
              role_next       = ROLE_ADDR_R;
              sub_next        = SUB_BIT_LOW;
              step_next       = ST_TX;
            end
            ST_RX_LOW: step_next = ST_RX_HI;
            ST_RX_HI: begin
              shift_byte_next = rx_byte;
              if (bit_index == 3'd0) begin
                bytes_left_next = (bytes_left == 8'd0) ? 8'd0 : bytes_left - 8'd1;
                res.read_valid  = 1'b1;
                res.read_data   = rx_byte;
                res.last_byte   = (bytes_left_next == 8'd0);
                step_next       = ST_MACK_LOW;
              end else begin
                bit_index_next = bit_index - 3'd1;
                step_next      = ST_RX_LOW;
              end
            end
            ST_MACK_LOW: step_next = ST_MACK_HI;
            ST_MACK_HI: begin
              if (bytes_left == 8'd0) begin
                step_next = ST_STOP_LOW;
              end else begin
                shift_byte_next = '0;
                bit_index_next  = 3'd7;
                step_next       = ST_RX_LOW;
              end
            end
            ST_STOP_LOW: step_next = ST_STOP_HI;
            ST_STOP_HI:  step_next = ST_STOP_REL;
            ST_STOP_REL: begin
              res.done_res = 1'b1;
              step_next    = ST_IDLE;
            end
            default: step_next = ST_IDLE;
          endcase
        end else begin
          phase_count_next = phase_inc[15:0];
        end
        // drop any illegal step code straight back to idle
        if (!$onehot(step)) begin
          step_next        = ST_IDLE;
          phase_count_next = '0;
        end
      end
    endcase

    // byte acknowledged or timed out: move on to what follows it
    if (ack_done) begin
      phase_count_next = '0;
      unique case (role)
        ROLE_ADDR_W: begin
          shift_byte_next = latched_register;
          bit_index_next  = 3'd7;
          role_next       = ROLE_REG;
          sub_next        = SUB_BIT_LOW;
        end
        ROLE_REG: begin
          if (is_read) begin
            step_next = ST_R_REL;
          end else begin
            shift_byte_next = latched_data;
            bit_index_next  = 3'd7;
            role_next       = ROLE_DATA;
            sub_next        = SUB_BIT_LOW;
          end
        end
        ROLE_DATA: step_next = ST_STOP_LOW;
        default: begin
          shift_byte_next = '0;
          bit_index_next  = 3'd7;
          step_next       = ST_RX_LOW;
        end
      endcase
    end

    // line levels after this tick
    res.scl         = 1'b1;
    res.sda_release = 1'b1;
    unique case (step_next)
      ST_TX: begin
        res.scl         = (sub_next == SUB_BIT_HIGH) || (sub_next == SUB_ACK_HIGH);
        res.sda_release = ((sub_next == SUB_BIT_LOW) || (sub_next == SUB_BIT_HIGH)) ?
                          shift_byte_next[bit_index_next] : 1'b1;
      end
      ST_S_FALL, ST_R_FALL: begin
        res.scl         = 1'b1;
        res.sda_release = 1'b0;
      end
      ST_S_LOW, ST_R_LOW, ST_STOP_LOW: begin
        res.scl         = 1'b0;
        res.sda_release = 1'b0;
      end
      ST_R_REL, ST_RX_LOW: begin
        res.scl         = 1'b0;
        res.sda_release = 1'b1;
      end
      ST_MACK_LOW: begin
        res.scl         = 1'b0;
        res.sda_release = (bytes_left_next == 8'd0);
      end
      ST_MACK_HI: begin
        res.scl         = 1'b1;
        res.sda_release = (bytes_left_next == 8'd0);
      end
      ST_STOP_HI: begin
        res.scl         = 1'b1;
        res.sda_release = 1'b0;
      end
      default: begin
        res.scl         = 1'b1;
        res.sda_release = 1'b1;
      end
    endcase
    res.busy_res = (step_next != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step             <= ST_IDLE;
      role             <= ROLE_ADDR_W;
      sub              <= SUB_BIT_LOW;
      phase_count      <= '0;
      bit_index        <= '0;
      shift_byte       <= '0;
      bytes_left       <= '0;
      ack_wait_count   <= '0;
      latched_device   <= '0;
      latched_register <= '0;
      latched_data     <= '0;
      is_read          <= 1'b0;
    end else if (advance) begin
      step             <= step_next;
      role             <= role_next;
      sub              <= sub_next;
      phase_count      <= phase_count_next;
      bit_index        <= bit_index_next;
      shift_byte       <= shift_byte_next;
      bytes_left       <= bytes_left_next;
      ack_wait_count   <= ack_wait_count_next;
      latched_device   <= latched_device_next;
      latched_register <= latched_register_next;
      latched_data     <= latched_data_next;
      is_read          <= is_read_next;
    end
  end

endmodule
